// ----- design/timed_valve_motor_controller_core_defines.svh -----
// Assertion helpers for the valve motor controller core.
`ifndef TIMED_VALVE_MOTOR_CONTROLLER_CORE_DEFINES_SVH
`define TIMED_VALVE_MOTOR_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TVMC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TVMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tvmc_pkg.sv -----
package tvmc_pkg;

	localparam int VALVE_COUNT = 3;
	localparam int VALVE_W     = 2;
	localparam int ACTION_W    = 2;
	localparam int TIME_W      = 32;
	localparam int TRAVEL_W    = 24;
	localparam int RELAY_W     = 2 * VALVE_COUNT;
	localparam int POS_W       = 2;

	// item packing
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = TRAVEL_W;

	localparam logic [TRAVEL_W-1:0] HALF_TRAVEL_RST = 24'd15000;
	localparam logic [TRAVEL_W-1:0] FULL_TRAVEL_RST = 24'd30000;

	typedef enum logic [0:0] {
		CMD_VALVE = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_OPEN       = 2'd0,
		ACT_HALF_OPEN  = 2'd1,
		ACT_HALF_CLOSE = 2'd2,
		ACT_CLOSE      = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HALF_TRAVEL = 2'd0,
		CFG_FULL_TRAVEL = 2'd1,
		CFG_CLOSE_CCW   = 2'd2,
		CFG_SPARE       = 2'd3
	} cfg_idx_t;

	typedef logic signed [POS_W-1:0] pos_t;

	localparam pos_t POS_CLOSED = -2'sd1;
	localparam pos_t POS_HALF   = 2'sd0;
	localparam pos_t POS_OPEN   = 2'sd1;

endpackage

// ----- design/timed_valve_motor_controller_core.sv -----
// Timed valve motor controller core: three valves, two relays each.
// An accepted item waits in the stage 1 input register and then moves on into the result register.
// Throughput: one item per cycle; stage 1 and the result register move on together,
// so the input only stalls while the result register is full and not being drained.
// Reset (arst_n low, asynchronous): positions half, no deadline armed,
// relays off, travel registers back to 15000 / 30000 ms, close_ccw 0.
`include "timed_valve_motor_controller_core_defines.svh"

module timed_valve_motor_controller_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side, lowest bit up: valve[1:0], action[3:2], now_ms[35:4], pad[39:36]
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tvmc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// tuser, lowest bit up: cmd[0]
	input  logic [tvmc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	// master side, lowest bit up: relay_drive[5:0], addressed_position[7:6],
	//                             accepted[8], motors_running[11:9], pad[15:12]
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tvmc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tvmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvmc_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import tvmc_pkg::*;

	// ---------------------------------------------------------------
	// configuration registers; always ready, sender keeps writes to idle spells
	// ---------------------------------------------------------------
	logic [TRAVEL_W-1:0] half_travel_q;
	logic [TRAVEL_W-1:0] full_travel_q;
	logic                close_ccw_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_travel_q <= HALF_TRAVEL_RST;
			full_travel_q <= FULL_TRAVEL_RST;
			close_ccw_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HALF_TRAVEL: half_travel_q <= cfg_data;
				CFG_FULL_TRAVEL: full_travel_q <= cfg_data;
				CFG_CLOSE_CCW:   close_ccw_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage 1: input register
	// ---------------------------------------------------------------
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [VALVE_W-1:0]  valve_s1;
	action_t             action_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                adv_s1;

	// stage 1 hands on when the result register is empty or being drained
	assign adv_s1        = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1    <= cmd_t'(s_axis_tuser[0]);
			valve_s1  <= s_axis_tdata[VALVE_W-1:0];
			action_s1 <= action_t'(s_axis_tdata[VALVE_W +: ACTION_W]);
			now_s1    <= s_axis_tdata[VALVE_W+ACTION_W +: TIME_W];
		end
	end

	// ---------------------------------------------------------------
	// valve state
	// ---------------------------------------------------------------
	pos_t                pos_q      [VALVE_COUNT];
	logic [TIME_W-1:0]   deadline_q [VALVE_COUNT];
	logic [VALVE_COUNT-1:0] armed_q;
	logic [RELAY_W-1:0]  relay_q;

	// ---------------------------------------------------------------
	// single pass: decide the move for the addressed valve, or release
	// expired motors on a tick
	// ---------------------------------------------------------------
	logic                valve_ok;
	pos_t                cur_pos;
	logic signed [2:0]   pos_sum;
	logic                start;
	logic                use_full;
	logic                opening;
	pos_t                target;
	logic [TRAVEL_W-1:0] span;
	logic [TIME_W-1:0]   deadline_new;
	logic                second_relay;

	pos_t                pos_d      [VALVE_COUNT];
	logic [TIME_W-1:0]   deadline_d [VALVE_COUNT];
	logic [VALVE_COUNT-1:0] armed_d;
	logic [RELAY_W-1:0]  relay_d;
	pos_t                out_pos;

	assign valve_ok = (valve_s1 < VALVE_W'(VALVE_COUNT));
	assign cur_pos  = valve_ok ? pos_q[valve_s1[VALVE_W-1:0]] : POS_HALF;

	// close guard: sum of all positions, range -3..3
	assign pos_sum = {pos_q[0][1], pos_q[0]} + {pos_q[1][1], pos_q[1]}
		+ {pos_q[2][1], pos_q[2]};

	always_comb begin
		start    = 1'b0;
		use_full = 1'b0;
		opening  = 1'b0;
		target   = cur_pos;
		case (action_s1)
			ACT_OPEN: begin
				opening = 1'b1;
				target  = POS_OPEN;
				if (cur_pos == POS_HALF) begin
					start = 1'b1;
				end else if (cur_pos == POS_CLOSED) begin
					start    = 1'b1;
					use_full = 1'b1;
				end
			end
			ACT_HALF_OPEN: begin
				opening = 1'b1;
				target  = POS_HALF;
				start   = (cur_pos == POS_CLOSED);
			end
			ACT_HALF_CLOSE: begin
				target = POS_HALF;
				start  = (cur_pos == POS_OPEN);
			end
			ACT_CLOSE: begin
				target = POS_CLOSED;
				if (!pos_sum[2]) begin
					if (cur_pos == POS_HALF) begin
						start = 1'b1;
					end else if (cur_pos == POS_OPEN) begin
						start    = 1'b1;
						use_full = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// gate: only valve commands to a real, idle motor
		if (cmd_s1 != CMD_VALVE || !valve_ok || armed_q[valve_s1[VALVE_W-1:0]]) begin
			start = 1'b0;
		end
	end

	assign span         = use_full ? full_travel_q : half_travel_q;
	assign deadline_new = now_s1 + {{(TIME_W-TRAVEL_W){1'b0}}, span};
	// second relay runs on opening moves when ccw is set, closing moves otherwise
	assign second_relay = (opening == close_ccw_q);

	always_comb begin
		relay_d = relay_q;
		armed_d = armed_q;
		for (int v = 0; v < VALVE_COUNT; v++) begin
			pos_d[v]      = pos_q[v];
			deadline_d[v] = deadline_q[v];
			if (cmd_s1 == CMD_TICK) begin
				if (armed_q[v] && (deadline_q[v] < now_s1)) begin
					armed_d[v]       = 1'b0;
					deadline_d[v]    = '0;
					relay_d[2*v +: 2] = 2'b00;
				end
			end else if (start && (valve_s1 == VALVE_W'(v))) begin
				armed_d[v]        = 1'b1;
				deadline_d[v]     = deadline_new;
				pos_d[v]          = target;
				relay_d[2*v]      = 1'b1;
				relay_d[2*v + 1]  = relay_q[2*v + 1] | second_relay;
			end
		end
		out_pos = valve_ok ? pos_d[valve_s1[VALVE_W-1:0]] : POS_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VALVE_COUNT; v++) begin
				pos_q[v] <= POS_HALF;
			end
			armed_q <= '0;
			relay_q <= '0;
		end else if (adv_s1) begin
			pos_q   <= pos_d;
			armed_q <= armed_d;
			relay_q <= relay_d;
		end
	end

	// stored deadline only matters while armed
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			deadline_q <= deadline_d;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: result register
	// ---------------------------------------------------------------
	logic                   valid_s2;
	logic [RELAY_W-1:0]     relay_s2;
	pos_t                   pos_s2;
	logic                   accepted_s2;
	logic [VALVE_COUNT-1:0] running_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			relay_s2    <= relay_d;
			pos_s2      <= out_pos;
			accepted_s2 <= start;
			running_s2  <= armed_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, running_s2, accepted_s2, pos_s2, relay_s2};

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	logic [VALVE_COUNT-1:0] pair_on;

	always_comb begin
		for (int v = 0; v < VALVE_COUNT; v++) begin
			pair_on[v] = |relay_q[2*v +: 2];
		end
	end

	// a relay is only ever on while its motor has an armed deadline
	`TVMC_ASSERT_NOW(a_relay_needs_armed, 1'b1, ((pair_on & ~armed_q) == '0), "relay on with no deadline")
	// an item leaving stage 1 always lands in the result register
	`TVMC_ASSERT_NEXT(a_adv_fills_out, adv_s1, m_axis_tvalid, "item lost between stages")
	// an accepted move reports at least one running motor
	`TVMC_ASSERT_NOW(a_accept_running, (m_axis_tvalid && accepted_s2), (running_s2 != '0), "accepted move with no motor running")

endmodule
